### sv/can_fdr_pkg.sv
// ---------------------------------------------------------------------------
// CAN frame descriptor ring package
// Shared beat types, mode and status codes, and the DLC length table.
// ---------------------------------------------------------------------------
package can_fdr_pkg;

  localparam int DEFAULT_RING_DEPTH = 16;

  // Pending-slot search works on groups of this many slots in its first level.
  localparam int SEARCH_GROUP = 16;
  localparam int SEARCH_LOC_W = 4;

  localparam logic [2:0] MODE_RECEIVE    = 3'd0;
  localparam logic [2:0] MODE_COPY_DONE  = 3'd1;
  localparam logic [2:0] MODE_COPY_ERROR = 3'd2;
  localparam logic [2:0] MODE_POP        = 3'd3;
  localparam logic [2:0] MODE_CLEAR_DROP = 3'd4;

  localparam logic [3:0] STATUS_STORED_PENDING = 4'd0;
  localparam logic [3:0] STATUS_STORED_READY   = 4'd1;
  localparam logic [3:0] STATUS_FULL_DROP      = 4'd2;
  localparam logic [3:0] STATUS_BUSY_DROP      = 4'd3;
  localparam logic [3:0] STATUS_COMPLETED      = 4'd4;
  localparam logic [3:0] STATUS_NONE_PENDING   = 4'd5;
  localparam logic [3:0] STATUS_POPPED         = 4'd6;
  localparam logic [3:0] STATUS_NOTHING        = 4'd7;
  localparam logic [3:0] STATUS_CLEARED        = 4'd8;

  localparam logic [31:0] PAYLOAD_OFFSET = 32'd8;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] fifo_status;
    logic [31:0] header_word0;
    logic [31:0] header_word1;
    logic [31:0] tick_ms;
    logic        copy_started;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  ack_index;
    logic [31:0] payload_address;
    logic [6:0]  copy_length;
    logic [10:0] frame_identifier;
    logic        frame_extended;
    logic [6:0]  frame_length;
    logic [31:0] frame_timestamp;
    logic        ring_empty;
    logic [31:0] drop_count;
  } out_item_t;

  typedef struct packed {
    logic [10:0] identifier;
    logic        extended;
    logic [6:0]  length;
    logic [31:0] timestamp;
  } desc_t;

  function automatic logic [6:0] dlc_length(input logic [3:0] dlc);
    logic [6:0] n;
    case (dlc)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'b000, dlc};
    endcase
    return n;
  endfunction

endpackage

### sv/can_fdr_desc_mem.sv
// ---------------------------------------------------------------------------
// Descriptor memory
// Single-write, single-read synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module can_fdr_desc_mem #(
  parameter int DEPTH = can_fdr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  can_fdr_pkg::desc_t       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output can_fdr_pkg::desc_t       rdata
);

  can_fdr_pkg::desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/can_fdr_pend_search.sv
// ---------------------------------------------------------------------------
// Pending slot search
// Finds the lowest slot awaiting copy completion: a registered first level
// over groups of slots, then a second level across the group results.
// ---------------------------------------------------------------------------
module can_fdr_pend_search #(
  parameter int DEPTH = can_fdr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic [DEPTH-1:0]         pending,
  output logic                     found,
  output logic [$clog2(DEPTH)-1:0] index
);

  localparam int GRP        = can_fdr_pkg::SEARCH_GROUP;
  localparam int LOC_W      = can_fdr_pkg::SEARCH_LOC_W;
  localparam int NUM_GROUPS = (DEPTH + GRP - 1) / GRP;
  localparam int PAD_W      = NUM_GROUPS * GRP;
  localparam int PTR_W      = $clog2(DEPTH);

  logic [PAD_W-1:0] pend_pad;
  logic             grp_any_next [NUM_GROUPS];
  logic [LOC_W-1:0] grp_loc_next [NUM_GROUPS];
  logic             grp_any      [NUM_GROUPS];
  logic [LOC_W-1:0] grp_loc      [NUM_GROUPS];

  assign pend_pad = PAD_W'(pending);

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_next[g] = 1'b0;
      grp_loc_next[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (pend_pad[g*GRP + b]) begin
          grp_any_next[g] = 1'b1;
          grp_loc_next[g] = LOC_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_any[g] <= grp_any_next[g];
        grp_loc[g] <= grp_loc_next[g];
      end
    end
  end

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        index = PTR_W'(g * GRP + int'(grp_loc[g]));
      end
    end
  end

endmodule

### sv/can_frame_descriptor_ring_core.sv
// ---------------------------------------------------------------------------
// CAN frame descriptor ring core
// Ring of received-frame descriptors with copy-pending and ready marks.
// ---------------------------------------------------------------------------
// Each command beat is accepted when start is high and busy is low: in the
// accept cycle the head descriptor is read from the descriptor RAM and the
// first level of the pending-slot search is registered; in the following
// cycle (busy high) the command executes and writes back the RAM and the
// slot marks. The result is presented on the next cycle with done high for
// exactly one cycle and must be taken then, since the receiver cannot stall
// it. A new command may be accepted in that same cycle, but not while the
// previous one executes.
// ---------------------------------------------------------------------------
module can_frame_descriptor_ring_core #(
  parameter int RING_DEPTH = can_fdr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  can_fdr_pkg::in_item_t  item,
  output logic                   done,
  output can_fdr_pkg::out_item_t result,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                 state;
  state_t                 state_next;
  can_fdr_pkg::in_item_t  item_q;
  logic [31:0]            fifo_base;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       wr_ptr_next;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W-1:0]       rd_ptr_next;
  logic [31:0]            drop_cnt;
  logic [31:0]            drop_cnt_next;
  logic [RING_DEPTH-1:0]  ready;
  logic [RING_DEPTH-1:0]  ready_next;
  logic [RING_DEPTH-1:0]  pending;
  logic [RING_DEPTH-1:0]  pending_next;
  can_fdr_pkg::out_item_t result_next;

  logic                   accept;
  logic                   exec;
  logic                   mem_we;
  can_fdr_pkg::desc_t     mem_wdata;
  can_fdr_pkg::desc_t     mem_rdata;
  logic                   pend_found;
  logic [PTR_W-1:0]       pend_index;
  logic [PTR_W-1:0]       wr_ptr_inc;
  logic [PTR_W-1:0]       rd_ptr_inc;
  logic [5:0]             ack;
  logic [31:0]            ack_times_72;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign accept = start && (state == ST_IDLE);
  assign exec   = (state == ST_EXEC);
  assign busy   = exec;

  assign wr_ptr_inc   = ring_next(wr_ptr);
  assign rd_ptr_inc   = ring_next(rd_ptr);
  assign ack          = item_q.fifo_status[13:8];
  assign ack_times_72 = {20'd0, ack, 6'd0} + {23'd0, ack, 3'd0};

  can_fdr_desc_mem #(
    .DEPTH (RING_DEPTH)
  ) u_desc_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  can_fdr_pend_search #(
    .DEPTH (RING_DEPTH)
  ) u_pend_search (
    .clk     (clk),
    .load    (accept),
    .pending (pending),
    .found   (pend_found),
    .index   (pend_index)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    drop_cnt_next = drop_cnt;
    ready_next    = ready;
    pending_next  = pending;
    mem_we        = 1'b0;
    mem_wdata.identifier = item_q.header_word0[28:18];
    mem_wdata.extended   = item_q.header_word0[30];
    mem_wdata.length     = can_fdr_pkg::dlc_length(item_q.header_word1[19:16]);
    mem_wdata.timestamp  = item_q.tick_ms;
    result_next        = '0;
    result_next.status = can_fdr_pkg::STATUS_NOTHING;

    case (item_q.mode)
      can_fdr_pkg::MODE_RECEIVE: begin
        result_next.ack_index = ack;
        if (wr_ptr_inc == rd_ptr) begin
          drop_cnt_next      = drop_cnt + 32'd1;
          result_next.status = can_fdr_pkg::STATUS_FULL_DROP;
        end else if (pending[wr_ptr]) begin
          result_next.status = can_fdr_pkg::STATUS_BUSY_DROP;
        end else begin
          mem_we                      = exec;
          result_next.payload_address = fifo_base + ack_times_72
                                        + can_fdr_pkg::PAYLOAD_OFFSET;
          result_next.copy_length     = mem_wdata.length;
          ready_next[wr_ptr]          = !item_q.copy_started;
          pending_next[wr_ptr]        = item_q.copy_started;
          wr_ptr_next                 = wr_ptr_inc;
          result_next.status          = item_q.copy_started
                                        ? can_fdr_pkg::STATUS_STORED_PENDING
                                        : can_fdr_pkg::STATUS_STORED_READY;
        end
      end
      can_fdr_pkg::MODE_COPY_DONE, can_fdr_pkg::MODE_COPY_ERROR: begin
        // A pending slot is never ready, so the lowest pending slot is the one.
        if (pend_found) begin
          ready_next[pend_index]   = 1'b1;
          pending_next[pend_index] = 1'b0;
          result_next.status       = can_fdr_pkg::STATUS_COMPLETED;
        end else begin
          result_next.status = can_fdr_pkg::STATUS_NONE_PENDING;
        end
      end
      can_fdr_pkg::MODE_POP: begin
        if ((rd_ptr != wr_ptr) && ready[rd_ptr]) begin
          result_next.frame_identifier = mem_rdata.identifier;
          result_next.frame_extended   = mem_rdata.extended;
          result_next.frame_length     = mem_rdata.length;
          result_next.frame_timestamp  = mem_rdata.timestamp;
          rd_ptr_next                  = rd_ptr_inc;
          result_next.status           = can_fdr_pkg::STATUS_POPPED;
        end
      end
      can_fdr_pkg::MODE_CLEAR_DROP: begin
        drop_cnt_next      = '0;
        result_next.status = can_fdr_pkg::STATUS_CLEARED;
      end
      default: result_next.status = can_fdr_pkg::STATUS_NOTHING;
    endcase

    result_next.ring_empty = (rd_ptr_next == wr_ptr_next);
    result_next.drop_count = drop_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      fifo_base <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      drop_cnt  <= '0;
      ready     <= '0;
      pending   <= '0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (cfg_we) begin
        fifo_base <= cfg_wdata;
      end
      if (exec) begin
        wr_ptr   <= wr_ptr_next;
        rd_ptr   <= rd_ptr_next;
        drop_cnt <= drop_cnt_next;
        ready    <= ready_next;
        pending  <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (exec) begin
      result <= result_next;
    end
  end

endmodule

### sv/can_fdr_checker.sv
// ---------------------------------------------------------------------------
// CAN frame descriptor ring port checker
// Concurrent checks on command, result and drop-counter behavior at the ports.
// ---------------------------------------------------------------------------
module can_fdr_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input can_fdr_pkg::out_item_t result
);

  // An accepted command always holds the core for exactly one execute cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_done : assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute cycle not followed by a single result beat");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a preceding execute cycle");

  // Dropped frames never carry a copy request.
  a_drop_no_copy : assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == can_fdr_pkg::STATUS_FULL_DROP
              || result.status == can_fdr_pkg::STATUS_BUSY_DROP))
      |-> (result.payload_address == 32'd0 && result.copy_length == 7'd0))
    else $error("dropped frame reports a payload copy");

  a_clear_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == can_fdr_pkg::STATUS_CLEARED)
      |-> (result.drop_count == 32'd0))
    else $error("clear command left a nonzero drop count");

endmodule

bind can_frame_descriptor_ring_core can_fdr_checker u_can_fdr_checker (.*);

### sim/can_frame_descriptor_ring_checker.sv
// ---------------------------------------------------------------------------
// CAN frame descriptor ring checker
// Watches the command and result channels of the descriptor ring, keeps its
// own copy of the ring state, and compares every result beat with the
// expected one in order of arrival.
// ---------------------------------------------------------------------------
module can_frame_descriptor_ring_checker #(
  parameter int RING_DEPTH = can_fdr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  can_fdr_pkg::in_item_t  item,
  input  logic                   done,
  input  can_fdr_pkg::out_item_t result,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata,
  output int                     mismatches,
  output int                     waiting,
  output int                     checked,
  output int                     full_drops
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Payload bytes per DLC code, index 15 leftmost.
  localparam logic [15:0][6:0] DLC_BYTES = {
    7'd64, 7'd48, 7'd32, 7'd24, 7'd20, 7'd16, 7'd12, 7'd8,
    7'd7,  7'd6,  7'd5,  7'd4,  7'd3,  7'd2,  7'd1,  7'd0
  };

  logic [31:0]            fifo_base;
  int unsigned            wr_ptr;
  int unsigned            rd_ptr;
  logic [31:0]            drop_total;
  can_fdr_pkg::desc_t     slot_desc    [RING_DEPTH];
  logic                   slot_ready   [RING_DEPTH];
  logic                   slot_pending [RING_DEPTH];
  can_fdr_pkg::out_item_t expected_results [$];

  task automatic clear_ring();
    fifo_base  = '0;
    wr_ptr     = 0;
    rd_ptr     = 0;
    drop_total = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      slot_desc[i]    = '0;
      slot_ready[i]   = 1'b0;
      slot_pending[i] = 1'b0;
    end
  endtask

  function automatic int unsigned ring_advance(input int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Applies one command to the ring copy and returns the result it causes.
  function automatic can_fdr_pkg::out_item_t apply_command(
      input can_fdr_pkg::in_item_t cmd);
    can_fdr_pkg::out_item_t r;
    int unsigned            nxt;
    logic [5:0]             fifo_index;
    r = '0;
    r.status = can_fdr_pkg::STATUS_NOTHING;
    case (cmd.mode)
      can_fdr_pkg::MODE_RECEIVE: begin
        nxt = ring_advance(wr_ptr);
        fifo_index = cmd.fifo_status[13:8];
        r.ack_index = fifo_index;
        if (nxt == rd_ptr) begin
          drop_total = drop_total + 32'd1;
          r.status = can_fdr_pkg::STATUS_FULL_DROP;
        end else if (slot_pending[wr_ptr]) begin
          r.status = can_fdr_pkg::STATUS_BUSY_DROP;
        end else begin
          r.payload_address = fifo_base + fifo_index * 32'd72 + 32'd8;
          slot_desc[wr_ptr].identifier = cmd.header_word0[28:18];
          slot_desc[wr_ptr].extended   = cmd.header_word0[30];
          slot_desc[wr_ptr].length     = DLC_BYTES[cmd.header_word1[19:16]];
          slot_desc[wr_ptr].timestamp  = cmd.tick_ms;
          r.copy_length = slot_desc[wr_ptr].length;
          slot_ready[wr_ptr]   = !cmd.copy_started;
          slot_pending[wr_ptr] = cmd.copy_started;
          r.status = cmd.copy_started ? can_fdr_pkg::STATUS_STORED_PENDING
                                      : can_fdr_pkg::STATUS_STORED_READY;
          wr_ptr = nxt;
        end
      end
      can_fdr_pkg::MODE_COPY_DONE, can_fdr_pkg::MODE_COPY_ERROR: begin
        r.status = can_fdr_pkg::STATUS_NONE_PENDING;
        for (int i = 0; i < RING_DEPTH; i++) begin
          if (slot_pending[i] && !slot_ready[i]) begin
            slot_ready[i]   = 1'b1;
            slot_pending[i] = 1'b0;
            r.status = can_fdr_pkg::STATUS_COMPLETED;
            break;
          end
        end
      end
      can_fdr_pkg::MODE_POP: begin
        if (rd_ptr != wr_ptr && slot_ready[rd_ptr]) begin
          r.frame_identifier = slot_desc[rd_ptr].identifier;
          r.frame_extended   = slot_desc[rd_ptr].extended;
          r.frame_length     = slot_desc[rd_ptr].length;
          r.frame_timestamp  = slot_desc[rd_ptr].timestamp;
          rd_ptr = ring_advance(rd_ptr);
          r.status = can_fdr_pkg::STATUS_POPPED;
        end
      end
      can_fdr_pkg::MODE_CLEAR_DROP: begin
        drop_total = '0;
        r.status = can_fdr_pkg::STATUS_CLEARED;
      end
      default: ;
    endcase
    r.ring_empty = (rd_ptr == wr_ptr);
    r.drop_count = drop_total;
    return r;
  endfunction

  task automatic show_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want)
      $display("  %s: expected 0x%0h, got 0x%0h", name, want, got);
  endtask

  always @(posedge clk) begin
    can_fdr_pkg::out_item_t want;
    if (rst) begin
      clear_ring();
      expected_results.delete();
    end else begin
      // The result of an earlier beat is matched first, since a new command
      // may be accepted in the same cycle that a result appears.
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Result beat with status %0d arrived with nothing expected",
                     result.status);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (result !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("Result beat %0d differs from the prediction:", checked);
              show_field("status", want.status, result.status);
              show_field("ack_index", want.ack_index, result.ack_index);
              show_field("payload_address", want.payload_address, result.payload_address);
              show_field("copy_length", want.copy_length, result.copy_length);
              show_field("frame_identifier", want.frame_identifier, result.frame_identifier);
              show_field("frame_extended", want.frame_extended, result.frame_extended);
              show_field("frame_length", want.frame_length, result.frame_length);
              show_field("frame_timestamp", want.frame_timestamp, result.frame_timestamp);
              show_field("ring_empty", want.ring_empty, result.ring_empty);
              show_field("drop_count", want.drop_count, result.drop_count);
            end
          end
        end
      end
      // A base written at this edge already applies to a command taken here.
      if (cfg_we)
        fifo_base = cfg_wdata;
      if (start && !busy) begin
        want = apply_command(item);
        if (want.status == can_fdr_pkg::STATUS_FULL_DROP)
          full_drops++;
        expected_results.push_back(want);
      end
    end
    waiting = expected_results.size();
  end

endmodule

### sim/can_frame_descriptor_ring_core_test.sv
// ---------------------------------------------------------------------------
// CAN frame descriptor ring core testbench
// Drives directed and random command beats with random gaps under several
// FIFO base addresses; a separate checker predicts and compares the results.
// ---------------------------------------------------------------------------
module can_frame_descriptor_ring_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_PER_SETTING = 160;
  localparam int STALL_LIMIT        = 200;
  localparam int SETTLE_CYCLES      = 8;
  localparam int MAX_GAP            = 14;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  can_fdr_pkg::in_item_t  item      = '0;
  logic                   cfg_we    = 1'b0;
  logic [31:0]            cfg_wdata = '0;
  logic                   busy;
  logic                   done;
  can_fdr_pkg::out_item_t result;

  int mismatches;
  int waiting;
  int checked;
  int full_drops;
  int stall_cycles   = 0;
  int commands_sent  = 0;
  int settings_used  = 0;

  can_frame_descriptor_ring_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  can_frame_descriptor_ring_checker ring_monitor (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked),
    .full_drops (full_drops)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("can_frame_descriptor_ring_core_test failed");
      $finish;
    end
  end

  // Busy only changes at a rising edge, so its value at the falling edge
  // tells whether the command is taken at the next rising edge.
  task automatic send_command(input can_fdr_pkg::in_item_t cmd, input int gap);
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= cmd;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    commands_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic can_fdr_pkg::in_item_t make_cmd(
      input logic [2:0] mode, input logic [31:0] fstat,
      input logic [31:0] h0, input logic [31:0] h1,
      input logic [31:0] tick, input logic started);
    can_fdr_pkg::in_item_t c;
    c.mode         = mode;
    c.fifo_status  = fstat;
    c.header_word0 = h0;
    c.header_word1 = h1;
    c.tick_ms      = tick;
    c.copy_started = started;
    return c;
  endfunction

  // While filling, receives outrun pops so the ring reaches its full state;
  // while draining, pops and completions dominate.
  function automatic can_fdr_pkg::in_item_t random_command(input bit filling);
    can_fdr_pkg::in_item_t c;
    int unsigned           pick;
    c.fifo_status  = $urandom();
    c.header_word0 = $urandom();
    c.header_word1 = $urandom();
    c.tick_ms      = $urandom();
    c.copy_started = ($urandom_range(0, 9) < 7);
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 55 : 25)) begin
      c.mode = can_fdr_pkg::MODE_RECEIVE;
    end else if (pick < (filling ? 72 : 50)) begin
      c.mode = $urandom_range(0, 1) ? can_fdr_pkg::MODE_COPY_DONE
                                    : can_fdr_pkg::MODE_COPY_ERROR;
    end else if (pick < 90) begin
      c.mode = can_fdr_pkg::MODE_POP;
    end else if (pick < 95) begin
      c.mode = can_fdr_pkg::MODE_CLEAR_DROP;
    end else begin
      c.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end
    return c;
  endfunction

  initial begin
    logic [31:0] base_values [4];
    bit          filling;
    bit          quiet;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the all-ones base makes the payload address wrap.
    write_base(32'hFFFF_FFFF);
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_COPY_DONE, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_COPY_ERROR, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_RECEIVE, '1, '1, '1, '1, 1'b1),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '1, '1, '1, '1, 1'b1),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_COPY_ERROR, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_RECEIVE, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_CLEAR_DROP, '1, '1, '1, '1, 1'b1),
                 $urandom_range(0, MAX_GAP));
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
      send_command(make_cmd(3'(m), '1, '1, '1, '1, 1'b1), $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_RECEIVE, 32'h0000_3F00, 32'h4000_0000,
                          32'h000F_0000, $urandom(), 1'b1), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_RECEIVE, 32'hFFFF_C0FF, 32'h1FFC_0000,
                          32'hFFF0_FFFF, $urandom(), 1'b1), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_COPY_DONE, '0, '0, '0, '0, 1'b0), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_COPY_DONE, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0), 0);
    send_command(make_cmd(can_fdr_pkg::MODE_POP, '0, '0, '0, '0, 1'b0),
                 $urandom_range(0, MAX_GAP));
    send_command(make_cmd(can_fdr_pkg::MODE_CLEAR_DROP, '0, '0, '0, '0, 1'b0), 0);

    base_values = '{32'h0000_0000, $urandom(), 32'hFFFF_FF00, $urandom()};
    foreach (base_values[p]) begin
      write_base(base_values[p]);
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        if (n % 40 == 0) begin
          filling = $urandom_range(0, 1);
          quiet   = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 49) == 0)
          drain_results();
        send_command(random_command(filling), quiet ? 0 : $urandom_range(0, MAX_GAP));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d command beats under %0d base address settings; %0d results checked,",
             commands_sent, settings_used, checked);
    $display("%0d of them full-ring drops, %0d mismatches.", full_drops, mismatches);
    if (mismatches == 0) begin
      $display("can_frame_descriptor_ring_core_test passed");
    end else begin
      $display("can_frame_descriptor_ring_core_test failed");
    end
    $finish;
  end

endmodule
